[hdl/ilws_pkg.sv]
`default_nettype none

package ilws_pkg;

   localparam int DATA_W   = 32;
   localparam int POS_W    = 7;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ    = 3'd0,
      CMD_REPLACE = 3'd1,
      CMD_APPEND  = 3'd2,
      CMD_INSERT  = 3'd3,
      CMD_DELETE  = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

`default_nettype wire

[hdl/ilws_cell.sv]
`default_nettype none

module ilws_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 6
) (
   input  wire logic                                clock,
   input  wire ilws_pkg::cell_ctl_type              ctl,
   input  wire logic                  [IDX_W-1:0]   target,
   input  wire logic signed [ilws_pkg::DATA_W-1:0]  left_data,
   input  wire logic signed [ilws_pkg::DATA_W-1:0]  right_data,
   output logic signed      [ilws_pkg::DATA_W-1:0]  data
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

   logic signed [ilws_pkg::DATA_W-1:0] data_ff;
   logic signed [ilws_pkg::DATA_W-1:0] data_in;
   logic                               hit;
   logic                               above;

   assign hit   = (MY_INDEX == target);
   assign above = (MY_INDEX > target);

   always_comb begin
      data_in = data_ff;
      unique case (ctl.op)
         ilws_pkg::CELL_WRITE: begin
            if (hit) data_in = ctl.value;
         end
         ilws_pkg::CELL_SHIFT_UP: begin
            if (hit) data_in = ctl.value;
            else if (above) data_in = left_data;
         end
         ilws_pkg::CELL_SHIFT_DOWN: begin
            if (hit || above) data_in = right_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

[hdl/indexed_list_with_shift.sv]
// Ordered list of signed 32-bit entries held in a row of DEPTH cells.
// Request channel (req_*): cmd, position, new_value. Commands are read,
// replace, append, insert (entries at and above position move up one cell)
// and delete (entries above position move down one cell). Unused codes
// return ok with no change.
// Response channel (rsp_*): one transaction per request with status
// (ok, index out of range, list full), read_data (zero unless a read
// succeeds) and fill_after, the entry count after the command (low 7 bits).
// The response is registered at the edge that accepts the request. All
// cells shift in parallel, so one command is taken per cycle while the
// response register drains every cycle.
// If rsp_ready is low the response register holds and req_ready drops
// until it is taken.
// Reset clears the fill count and the response valid; cell contents are
// unknown until written, but only entries below the fill count are ever read.
`default_nettype none

module indexed_list_with_shift #(
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic        [ilws_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic        [ilws_pkg::POS_W-1:0]     req_position,
   input  wire logic signed [ilws_pkg::DATA_W-1:0]    req_new_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic             [ilws_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed      [ilws_pkg::DATA_W-1:0]    rsp_read_data,
   output logic             [ilws_pkg::FILL_W-1:0]    rsp_fill_after
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > ilws_pkg::POS_W) ? CNT_W : ilws_pkg::POS_W;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   ilws_pkg::status_type                   rsp_status_ff;
   ilws_pkg::status_type                   rsp_status_in;
   logic signed [ilws_pkg::DATA_W-1:0]     rsp_read_data_ff;
   logic signed [ilws_pkg::DATA_W-1:0]     rsp_read_data_in;

   logic                                   accept;
   logic [CMP_W-1:0]                       pos_ext;
   logic [CMP_W-1:0]                       cnt_ext;
   logic                                   in_range;
   logic                                   ins_range;
   logic                                   full;
   logic [IDX_W-1:0]                       pos_idx;
   ilws_pkg::cmd_type                      cmd;
   ilws_pkg::cell_ctl_type                 ctl;
   logic [IDX_W-1:0]                       target;
   logic signed [ilws_pkg::DATA_W-1:0]     cell_data [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign pos_ext   = CMP_W'(req_position);
   assign cnt_ext   = CMP_W'(count_ff);
   assign in_range  = (pos_ext < cnt_ext);
   assign ins_range = (pos_ext <= cnt_ext);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pos_idx   = pos_ext[IDX_W-1:0];
   assign cmd       = ilws_pkg::cmd_type'(req_cmd);

   always_comb begin
      count_in         = count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_read_data_in = rsp_read_data_ff;
      ctl.op           = ilws_pkg::CELL_HOLD;
      ctl.value        = req_new_value;
      target           = pos_idx;
      if (accept) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = ilws_pkg::ST_OK;
         rsp_read_data_in = '0;
         unique case (cmd)
            ilws_pkg::CMD_READ: begin
               if (in_range) rsp_read_data_in = cell_data[pos_idx];
               else rsp_status_in = ilws_pkg::ST_RANGE;
            end
            ilws_pkg::CMD_REPLACE: begin
               if (in_range) ctl.op = ilws_pkg::CELL_WRITE;
               else rsp_status_in = ilws_pkg::ST_RANGE;
            end
            ilws_pkg::CMD_APPEND: begin
               target = count_ff[IDX_W-1:0];
               if (full) begin
                  rsp_status_in = ilws_pkg::ST_FULL;
               end else begin
                  ctl.op   = ilws_pkg::CELL_WRITE;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ilws_pkg::CMD_INSERT: begin
               if (!ins_range) begin
                  rsp_status_in = ilws_pkg::ST_RANGE;
               end else if (full) begin
                  rsp_status_in = ilws_pkg::ST_FULL;
               end else begin
                  ctl.op   = ilws_pkg::CELL_SHIFT_UP;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ilws_pkg::CMD_DELETE: begin
               if (in_range) begin
                  ctl.op   = ilws_pkg::CELL_SHIFT_DOWN;
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  rsp_status_in = ilws_pkg::ST_RANGE;
               end
            end
            default: rsp_status_in = ilws_pkg::ST_OK;
         endcase
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [ilws_pkg::DATA_W-1:0] left_data;
      logic signed [ilws_pkg::DATA_W-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end
      ilws_cell #(
         .INDEX (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .target     (target),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff    <= rsp_status_in;
      rsp_read_data_ff <= rsp_read_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_fill_after = ilws_pkg::FILL_W'(count_ff);

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   localparam int LIST_DEPTH = 64;
   localparam int CYCLE_LIMIT = 100000;
   localparam int IDLE_PCT = 27;
   localparam int CMD_W = ilws_pkg::CMD_W;
   localparam int POS_W = ilws_pkg::POS_W;
   localparam int DATA_W = ilws_pkg::DATA_W;
   localparam int STATUS_W = ilws_pkg::STATUS_W;
   localparam int FILL_W = ilws_pkg::FILL_W;
   localparam int POS_MAX = (1 << POS_W) - 1;
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;

   typedef struct packed {
      ilws_pkg::status_type     status;
      logic signed [DATA_W-1:0] read_data;
      logic [FILL_W-1:0]        fill_after;
   } list_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CMD_W-1:0] req_cmd = '0;
   logic [POS_W-1:0] req_position = '0;
   logic signed [DATA_W-1:0] req_new_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic signed [DATA_W-1:0] rsp_read_data;
   logic [FILL_W-1:0] rsp_fill_after;

   logic signed [DATA_W-1:0] list_cells [LIST_DEPTH];
   logic [FILL_W-1:0] list_fill = '0;
   list_outcome_type awaited_outcomes [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   bit quiet_mode = 1'b0;
   int holdoff_request = 0;
   int holdoff_left = 0;

   indexed_list_with_shift #(.DEPTH(LIST_DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_new_value  (req_new_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .rsp_fill_after (rsp_fill_after)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(string what, longint want, longint got);
      mismatch_count++;
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   // updates the list copy and returns the response the command should produce
   function automatic list_outcome_type apply_list_command(logic [CMD_W-1:0] cmd,
                                                           logic [POS_W-1:0] pos,
                                                           logic signed [DATA_W-1:0] value);
      list_outcome_type res;
      int i;
      res.status = ilws_pkg::ST_OK;
      res.read_data = '0;
      case (cmd)
         ilws_pkg::CMD_READ: begin
            if (pos < list_fill) res.read_data = list_cells[pos];
            else res.status = ilws_pkg::ST_RANGE;
         end
         ilws_pkg::CMD_REPLACE: begin
            if (pos < list_fill) list_cells[pos] = value;
            else res.status = ilws_pkg::ST_RANGE;
         end
         ilws_pkg::CMD_APPEND: begin
            if (list_fill >= LIST_DEPTH) begin
               res.status = ilws_pkg::ST_FULL;
            end else begin
               list_cells[list_fill] = value;
               list_fill++;
            end
         end
         ilws_pkg::CMD_INSERT: begin
            if (pos > list_fill) begin
               res.status = ilws_pkg::ST_RANGE;
            end else if (list_fill >= LIST_DEPTH) begin
               res.status = ilws_pkg::ST_FULL;
            end else begin
               for (i = int'(list_fill); i > int'(pos); i--) list_cells[i] = list_cells[i-1];
               list_cells[pos] = value;
               list_fill++;
            end
         end
         ilws_pkg::CMD_DELETE: begin
            if (pos < list_fill) begin
               for (i = int'(pos); i + 1 < int'(list_fill); i++)
                  list_cells[i] = list_cells[i+1];
               list_fill--;
            end else begin
               res.status = ilws_pkg::ST_RANGE;
            end
         end
         default: ;
      endcase
      res.fill_after = list_fill;
      return res;
   endfunction

   // response check first, then prediction of the transaction accepted at this edge
   always @(posedge clock) begin
      list_outcome_type want;
      if (reset) begin
         list_fill = '0;
         awaited_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("unexpected response, status", -1, rsp_status);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", want.status, rsp_status);
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", want.read_data, rsp_read_data);
               if (rsp_fill_after !== want.fill_after)
                  report_mismatch("fill_after", want.fill_after, rsp_fill_after);
            end
         end
         if (req_valid && req_ready)
            awaited_outcomes.push_back(apply_list_command(req_cmd, req_position,
                                                          req_new_value));
      end
   end

   always @(negedge clock) begin
      if (holdoff_request != 0) begin
         holdoff_left = holdoff_request;
         holdoff_request = 0;
      end
      if (reset) begin
         rsp_ready = 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_ready = 1'b0;
         holdoff_left--;
      end else if (quiet_mode) begin
         rsp_ready = 1'b1;
      end else begin
         rsp_ready = ($urandom_range(99, 0) >= IDLE_PCT);
      end
   end

   // entered and left at a falling edge
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] value);
      if (!quiet_mode && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid = 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_position = pos;
      req_new_value = value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic logic [POS_W-1:0] pick_position(bit allow_end);
      if ($urandom_range(3, 0) == 0 || (list_fill == 0 && !allow_end))
         return POS_W'($urandom_range(POS_MAX, 0));
      if (allow_end) return POS_W'($urandom_range(list_fill, 0));
      return POS_W'($urandom_range(list_fill - 1, 0));
   endfunction

   task automatic send_random_command(bit grow);
      int r;
      logic signed [DATA_W-1:0] value;
      r = $urandom_range(99, 0);
      value = $urandom;
      if (r < 8)
         send_command(CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)),
                      POS_W'($urandom_range(POS_MAX, 0)), value);
      else if (r < 25)
         send_command(ilws_pkg::CMD_READ, pick_position(1'b0), value);
      else if (r < 38)
         send_command(ilws_pkg::CMD_REPLACE, pick_position(1'b0), value);
      else if (r < (grow ? 62 : 48))
         send_command(ilws_pkg::CMD_APPEND, pick_position(1'b1), value);
      else if (r < (grow ? 90 : 60))
         send_command(ilws_pkg::CMD_INSERT, pick_position(1'b1), value);
      else
         send_command(ilws_pkg::CMD_DELETE, pick_position(1'b0), value);
   endtask

   task automatic test_directed_edges;
      int c;
      send_command(ilws_pkg::CMD_READ, POS_W'(0), '0);
      send_command(ilws_pkg::CMD_REPLACE, POS_W'(0), 32'sd7);
      send_command(ilws_pkg::CMD_DELETE, POS_W'(0), '0);
      send_command(ilws_pkg::CMD_INSERT, POS_W'(1), 32'sd9);
      send_command(ilws_pkg::CMD_INSERT, POS_W'(0), 32'sd5);
      send_command(ilws_pkg::CMD_APPEND, POS_W'(0), 32'sh7FFF_FFFF);
      send_command(ilws_pkg::CMD_APPEND, POS_W'(POS_MAX), 32'sh8000_0000);
      send_command(ilws_pkg::CMD_INSERT, POS_W'(3), -32'sd1);
      for (c = 0; c <= 4; c++) send_command(ilws_pkg::CMD_READ, POS_W'(c), '0);
      send_command(ilws_pkg::CMD_READ, POS_W'(POS_MAX), '0);
      send_command(ilws_pkg::CMD_REPLACE, POS_W'(2), 32'sh1234_5678);
      send_command(ilws_pkg::CMD_INSERT, POS_W'(1), 32'sd0);
      send_command(ilws_pkg::CMD_DELETE, POS_W'(0), '0);
      send_command(ilws_pkg::CMD_DELETE, POS_W'(list_fill - 1), '0);
      for (c = int'(CMD_SPARE_FIRST); c <= int'(CMD_SPARE_LAST); c++)
         send_command(CMD_W'(c), POS_W'($urandom_range(POS_MAX, 0)), $urandom);
      send_command(ilws_pkg::CMD_REPLACE, POS_W'(POS_MAX), 32'sd3);
      send_command(ilws_pkg::CMD_DELETE, POS_W'(POS_MAX), '0);
      send_command(ilws_pkg::CMD_INSERT, POS_W'(POS_MAX), 32'sd3);
      for (c = 0; c < int'(list_fill); c++) send_command(ilws_pkg::CMD_READ, POS_W'(c), '0);
   endtask

   task automatic test_full_list;
      while (list_fill < LIST_DEPTH) begin
         if ($urandom_range(1, 0))
            send_command(ilws_pkg::CMD_APPEND, POS_W'(0), $urandom);
         else
            send_command(ilws_pkg::CMD_INSERT, POS_W'($urandom_range(list_fill, 0)),
                         $urandom);
      end
      send_command(ilws_pkg::CMD_APPEND, POS_W'(0), $urandom);
      send_command(ilws_pkg::CMD_INSERT, POS_W'($urandom_range(LIST_DEPTH - 1, 0)), $urandom);
      send_command(ilws_pkg::CMD_INSERT, POS_W'(LIST_DEPTH), $urandom);
      send_command(ilws_pkg::CMD_INSERT, POS_W'(LIST_DEPTH + 1), $urandom);
      send_command(ilws_pkg::CMD_READ, POS_W'(LIST_DEPTH - 1), '0);
      send_command(ilws_pkg::CMD_READ, POS_W'(LIST_DEPTH), '0);
      send_command(ilws_pkg::CMD_REPLACE, POS_W'(LIST_DEPTH - 1), $urandom);
      send_command(ilws_pkg::CMD_READ, POS_W'(LIST_DEPTH - 1), '0);
      send_command(ilws_pkg::CMD_DELETE, POS_W'(LIST_DEPTH - 1), '0);
      send_command(ilws_pkg::CMD_APPEND, POS_W'(0), $urandom);
      while (list_fill > 0) begin
         if ($urandom_range(3, 0) == 0)
            send_command(ilws_pkg::CMD_READ, POS_W'($urandom_range(list_fill - 1, 0)), '0);
         send_command(ilws_pkg::CMD_DELETE, POS_W'($urandom_range(list_fill - 1, 0)), '0);
      end
   endtask

   task automatic test_random_mix;
      int n;
      bit grow;
      grow = 1'b1;
      for (n = 0; n < 100; n++) begin
         if (n % 50 == 49) grow = !grow;
         send_random_command(grow);
      end
   endtask

   task automatic test_response_holdoff;
      int n;
      holdoff_request = 40;
      for (n = 0; n < 20; n++) send_random_command(1'b1);
   endtask

   task automatic test_back_to_back;
      int n;
      quiet_mode = 1'b1;
      for (n = 0; n < 60; n++) send_random_command(n < 30);
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_edges();
      test_full_list();
      test_random_mix();
      test_response_holdoff();
      test_back_to_back();
      test_random_mix();
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
